>>> rtl/sppi_pkg.sv
// shared constants for the smoothed speed pi regulator
// no dependencies

`default_nettype none

package sppi_pkg;

    // clamp applied to the integral and proportional terms, in hundredths
    localparam int TERM_LIMIT = 300000;

    // field widths
    localparam int SPEED_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int PERIOD_W = 8;
    localparam int DRIVE_W  = 21;

    // internal widths
    localparam int ERR_W    = SPEED_W + 2;               // target minus average
    localparam int EMAG_W   = SPEED_W + 1;               // |error|
    localparam int MULT_W   = GAIN_W + 1;                // gain, doubled in band
    localparam int PROD_W   = ERR_W + MULT_W + 1;        // signed product
    localparam int CSUM_W   = PROD_W + 1;                // integral plus product
    localparam int INTEG_W  = $clog2(TERM_LIMIT + 1) + 1;
    localparam int SUM_W    = DRIVE_W + 2;               // p plus integral
    localparam int DIFF_W   = DRIVE_W + 1;               // new minus old output
    localparam int TPROD_W  = DIFF_W + PERIOD_W;         // |diff| * factor
    localparam int CNT_W    = 5;

    // register indexes on the configuration port
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_SPEED  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_KP_CENTI      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KI_CENTI      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_NEAR_BAND     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SMOOTH_PERIOD = 3'd4;

    // reset values
    localparam logic [GAIN_W-1:0]   NEAR_BAND_RST     = 16'd180;
    localparam logic [PERIOD_W-1:0] SMOOTH_PERIOD_RST = 8'd20;

    // operation codes
    localparam logic OP_CONTROL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

endpackage

`default_nettype wire

>>> rtl/speed_pi_with_smoothed_output.sv
// speed pi regulator with interpolated output, bit-serial datapath
// depends on sppi_pkg

// usage
//   input words (s_*) carry op, enable, two encoder counts and a slot index.
//   op control: average of the counts (truncated toward zero) is compared
//   with target_speed; p and integral products are formed one multiplier
//   bit per cycle, clamped to +-TERM_LIMIT, summed, and the new output
//   (clamped to 21 bits) is returned with the two clamp flags.
//   op tick: returns old + (new - old) * min(slot+1, period) / period, the
//   product formed one factor bit per cycle and the quotient by restoring
//   division one quotient bit per cycle.
//   enable low clears integral and both output registers and returns zero.
//   steps: a control word runs 17 multiply steps plus clamp, sum and output
//   load; a tick runs 8 multiply steps, 22 divide steps, fix-up and load;
//   a disabled word goes straight to the output load.
//   one word is in flight at a time; s_ready is high only while idle, so the
//   next word is accepted only once the last has gone to the output register.
//   a finished word sits in the output register until m_ready; the next
//   input word is accepted meanwhile and waits for the register at its end.
//   configuration: cfg_wr_en writes cfg_wdata to register cfg_addr at once;
//   only write while no word is in flight. indexes above four are ignored.
//   aresetn (synchronous, active low) restores defaults, clears state and handshakes

`default_nettype none

module speed_pi_with_smoothed_output (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // configuration write port
    input  wire logic                                  cfg_wr_en,
    input  wire logic [sppi_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  wire logic [sppi_pkg::GAIN_W-1:0]           cfg_wdata,
    // input words
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_op,
    input  wire logic                                  s_enable,
    input  wire logic signed [sppi_pkg::SPEED_W-1:0]   s_left_pulses,
    input  wire logic signed [sppi_pkg::SPEED_W-1:0]   s_right_pulses,
    input  wire logic [sppi_pkg::PERIOD_W-1:0]         s_slot,
    // result words
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [sppi_pkg::DRIVE_W-1:0]        m_drive,
    output logic                                       m_integral_saturated,
    output logic                                       m_p_saturated
);
    import sppi_pkg::*;

    // sequencer codes
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [ST_W-1:0] ST_MUL   = 3'd1;   // p and integral products
    localparam logic [ST_W-1:0] ST_CLAMP = 3'd2;   // term clamps
    localparam logic [ST_W-1:0] ST_SUM   = 3'd3;   // output sum and commit
    localparam logic [ST_W-1:0] ST_TMUL  = 3'd4;   // |diff| * factor
    localparam logic [ST_W-1:0] ST_TDIV  = 3'd5;   // divide by period
    localparam logic [ST_W-1:0] ST_TFIN  = 3'd6;   // sign and offset
    localparam logic [ST_W-1:0] ST_DONE  = 3'd7;   // wait for output register

    localparam int QUO_W = DIFF_W;
    localparam int REM_W = PERIOD_W;
    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MULT_W - 1);
    localparam logic [CNT_W-1:0] TMUL_LAST = CNT_W'(PERIOD_W - 1);
    localparam logic [CNT_W-1:0] TDIV_LAST = CNT_W'(QUO_W - 1);

    localparam logic signed [CSUM_W-1:0]  LIM_HI   = CSUM_W'(TERM_LIMIT);
    localparam logic signed [CSUM_W-1:0]  LIM_LO   = -LIM_HI;
    localparam logic signed [SUM_W-1:0]   DRV_MAX  = SUM_W'((1 << (DRIVE_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0]   DRV_MIN  = -SUM_W'(1 << (DRIVE_W - 1));
    localparam logic signed [INTEG_W-1:0] ILIM_HI  = INTEG_W'(TERM_LIMIT);
    localparam logic signed [INTEG_W-1:0] ILIM_LO  = -ILIM_HI;

    // configuration registers
    logic signed [SPEED_W-1:0] target_reg;
    logic [GAIN_W-1:0]         kp_reg;
    logic [GAIN_W-1:0]         ki_reg;
    logic [GAIN_W-1:0]         band_reg;
    logic [PERIOD_W-1:0]       period_reg;

    // regulator state
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [DRIVE_W-1:0] prev_reg, prev_next;
    logic signed [DRIVE_W-1:0] cur_reg, cur_next;

    // sequencer
    logic [ST_W-1:0]  state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // control datapath
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic [MULT_W-1:0]         mkp_reg, mkp_next;
    logic [MULT_W-1:0]         mki_reg, mki_next;
    logic signed [PROD_W-1:0]  prodp_reg, prodp_next;
    logic signed [PROD_W-1:0]  prodi_reg, prodi_next;
    logic signed [INTEG_W-1:0] pterm_reg, pterm_next;
    logic                      ihit_reg, ihit_next;
    logic                      phit_reg, phit_next;

    // tick datapath
    logic [DIFF_W-1:0]   dmag_reg, dmag_next;
    logic                neg_reg, neg_next;
    logic [PERIOD_W-1:0] fac_reg, fac_next;
    logic [PERIOD_W-1:0] per_reg, per_next;
    logic [TPROD_W:0]    tprod_reg, tprod_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;

    // finished word waiting for the output register
    logic signed [DRIVE_W-1:0] res_drive_reg, res_drive_next;
    logic                      res_ih_reg, res_ih_next;
    logic                      res_ph_reg, res_ph_next;

    // output register
    logic                      m_valid_reg, m_valid_next;
    logic signed [DRIVE_W-1:0] m_drive_reg, m_drive_next;
    logic                      m_ih_reg, m_ih_next;
    logic                      m_ph_reg, m_ph_next;

    // front end of a control word
    logic signed [SPEED_W:0]   sum_lr;
    logic signed [SPEED_W:0]   sum_adj;
    logic signed [SPEED_W:0]   speed;
    logic signed [ERR_W-1:0]   err_in;
    logic signed [ERR_W-1:0]   err_neg;
    logic [EMAG_W-1:0]         emag;
    logic [MULT_W-1:0]         gain;

    // front end of a tick
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  diff_neg;
    logic [PERIOD_W-1:0]       per_in;
    logic [PERIOD_W:0]         slot_inc;
    logic [PERIOD_W-1:0]       fac_in;

    // step logic
    logic signed [ERR_W:0]     hi_p;
    logic signed [ERR_W:0]     hi_i;
    logic [DIFF_W:0]           hi_t;
    logic [TPROD_W:0]          tprod_step;
    logic [REM_W+1:0]          trial;
    logic signed [CSUM_W-1:0]  isum;
    logic signed [CSUM_W-1:0]  psum;
    logic signed [SUM_W-1:0]   osum;
    logic signed [DRIVE_W-1:0] oclamp;
    logic signed [QUO_W:0]     squo;
    logic signed [QUO_W+1:0]   tval;

    logic in_fire;
    logic out_free;

    assign s_ready              = (state_reg == ST_IDLE);
    assign in_fire              = s_valid && s_ready;
    assign out_free             = !m_valid_reg || m_ready;
    assign m_valid              = m_valid_reg;
    assign m_drive              = m_drive_reg;
    assign m_integral_saturated = m_ih_reg;
    assign m_p_saturated        = m_ph_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            kp_reg     <= '0;
            ki_reg     <= '0;
            band_reg   <= NEAR_BAND_RST;
            period_reg <= SMOOTH_PERIOD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_TARGET_SPEED:  target_reg <= $signed(cfg_wdata);
                CFG_KP_CENTI:      kp_reg     <= cfg_wdata;
                CFG_KI_CENTI:      ki_reg     <= cfg_wdata;
                CFG_NEAR_BAND:     band_reg   <= cfg_wdata;
                CFG_SMOOTH_PERIOD: period_reg <= cfg_wdata[PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // speed error: average truncated toward zero, then target minus it
    always_comb begin
        sum_lr  = (SPEED_W + 1)'(s_left_pulses) + (SPEED_W + 1)'(s_right_pulses);
        sum_adj = sum_lr + $signed({{SPEED_W{1'b0}}, sum_lr[SPEED_W]});
        speed   = sum_adj >>> 1;
        err_in  = ERR_W'(target_reg) - ERR_W'(speed);
        err_neg = -err_in;
        emag    = err_in[ERR_W-1] ? err_neg[EMAG_W-1:0] : err_in[EMAG_W-1:0];
        // integral gain doubles inside the near band
        gain    = (emag < EMAG_W'(band_reg)) ? {ki_reg, 1'b0} : {1'b0, ki_reg};
    end

    // tick operands: |new - old|, period (zero read as one), saturated factor
    always_comb begin
        diff     = DIFF_W'(cur_reg) - DIFF_W'(prev_reg);
        diff_neg = -diff;
        per_in   = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
        slot_inc = (PERIOD_W + 1)'(s_slot) + (PERIOD_W + 1)'(1);
        fac_in   = (slot_inc > (PERIOD_W + 1)'(per_in)) ? per_in
                                                         : slot_inc[PERIOD_W-1:0];
    end

    // one multiplier bit per cycle, lsb first, partial sum shifted right
    always_comb begin
        hi_p = prodp_reg[PROD_W-1:MULT_W] + (mkp_reg[0] ? (ERR_W + 1)'(err_reg) : '0);
        hi_i = prodi_reg[PROD_W-1:MULT_W] + (mki_reg[0] ? (ERR_W + 1)'(err_reg) : '0);
        hi_t = tprod_reg[TPROD_W:PERIOD_W] + (fac_reg[0] ? {1'b0, dmag_reg} : '0);
        tprod_step = {hi_t, tprod_reg[PERIOD_W-1:0]} >> 1;
        // restoring divide step on the remainder and next dividend bit
        trial = {1'b0, rem_reg, quo_reg[QUO_W-1]} - {2'b00, per_reg};
    end

    // clamps and final sums
    always_comb begin
        isum = CSUM_W'(integ_reg) + CSUM_W'(prodi_reg);
        psum = CSUM_W'(prodp_reg);
        osum = SUM_W'(pterm_reg) + SUM_W'(integ_reg);
        if (osum > DRV_MAX) begin
            oclamp = DRV_MAX[DRIVE_W-1:0];
        end else if (osum < DRV_MIN) begin
            oclamp = DRV_MIN[DRIVE_W-1:0];
        end else begin
            oclamp = osum[DRIVE_W-1:0];
        end
        squo = neg_reg ? -(QUO_W + 1)'(quo_reg) : (QUO_W + 1)'(quo_reg);
        tval = (QUO_W + 2)'(squo) + (QUO_W + 2)'(prev_reg);
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        integ_next     = integ_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        err_next       = err_reg;
        mkp_next       = mkp_reg;
        mki_next       = mki_reg;
        prodp_next     = prodp_reg;
        prodi_next     = prodi_reg;
        pterm_next     = pterm_reg;
        ihit_next      = ihit_reg;
        phit_next      = phit_reg;
        dmag_next      = dmag_reg;
        neg_next       = neg_reg;
        fac_next       = fac_reg;
        per_next       = per_reg;
        tprod_next     = tprod_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        res_drive_next = res_drive_reg;
        res_ih_next    = res_ih_reg;
        res_ph_next    = res_ph_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_drive_next   = m_drive_reg;
        m_ih_next      = m_ih_reg;
        m_ph_next      = m_ph_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cnt_next = '0;
                    if (!s_enable) begin
                        // disabled: clear state, answer zero
                        integ_next     = '0;
                        prev_next      = '0;
                        cur_next       = '0;
                        res_drive_next = '0;
                        res_ih_next    = 1'b0;
                        res_ph_next    = 1'b0;
                        state_next     = ST_DONE;
                    end else if (s_op == OP_CONTROL) begin
                        err_next   = err_in;
                        mkp_next   = {1'b0, kp_reg};
                        mki_next   = gain;
                        prodp_next = '0;
                        prodi_next = '0;
                        state_next = ST_MUL;
                    end else begin
                        dmag_next  = diff[DIFF_W-1] ? diff_neg : diff;
                        neg_next   = diff[DIFF_W-1];
                        fac_next   = fac_in;
                        per_next   = per_in;
                        tprod_next = '0;
                        state_next = ST_TMUL;
                    end
                end
            end
            ST_MUL: begin
                prodp_next = $signed({hi_p, prodp_reg[MULT_W-1:0]}) >>> 1;
                prodi_next = $signed({hi_i, prodi_reg[MULT_W-1:0]}) >>> 1;
                mkp_next   = mkp_reg >> 1;
                mki_next   = mki_reg >> 1;
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == MUL_LAST) begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                ihit_next = (isum >= LIM_HI) || (isum <= LIM_LO);
                phit_next = (psum >= LIM_HI) || (psum <= LIM_LO);
                if (isum >= LIM_HI) begin
                    integ_next = ILIM_HI;
                end else if (isum <= LIM_LO) begin
                    integ_next = ILIM_LO;
                end else begin
                    integ_next = isum[INTEG_W-1:0];
                end
                if (psum >= LIM_HI) begin
                    pterm_next = ILIM_HI;
                end else if (psum <= LIM_LO) begin
                    pterm_next = ILIM_LO;
                end else begin
                    pterm_next = psum[INTEG_W-1:0];
                end
                state_next = ST_SUM;
            end
            ST_SUM: begin
                prev_next      = cur_reg;
                cur_next       = oclamp;
                res_drive_next = oclamp;
                res_ih_next    = ihit_reg;
                res_ph_next    = phit_reg;
                state_next     = ST_DONE;
            end
            ST_TMUL: begin
                fac_next = fac_reg >> 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == TMUL_LAST) begin
                    // quotient fits in QUO_W bits, so the top bits start
                    // as the remainder
                    rem_next   = tprod_step[TPROD_W-1:QUO_W];
                    quo_next   = tprod_step[QUO_W-1:0];
                    cnt_next   = '0;
                    state_next = ST_TDIV;
                end else begin
                    tprod_next = tprod_step;
                end
            end
            ST_TDIV: begin
                if (!trial[REM_W+1]) begin
                    rem_next = trial[REM_W-1:0];
                end else begin
                    rem_next = {rem_reg[REM_W-2:0], quo_reg[QUO_W-1]};
                end
                quo_next = {quo_reg[QUO_W-2:0], !trial[REM_W+1]};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == TDIV_LAST) begin
                    state_next = ST_TFIN;
                end
            end
            ST_TFIN: begin
                res_drive_next = tval[DRIVE_W-1:0];
                res_ih_next    = 1'b0;
                res_ph_next    = 1'b0;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_drive_next = res_drive_reg;
                    m_ih_next    = res_ih_reg;
                    m_ph_next    = res_ph_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and regulator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            integ_reg   <= '0;
            prev_reg    <= '0;
            cur_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            integ_reg   <= integ_next;
            prev_reg    <= prev_next;
            cur_reg     <= cur_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        err_reg       <= err_next;
        mkp_reg       <= mkp_next;
        mki_reg       <= mki_next;
        prodp_reg     <= prodp_next;
        prodi_reg     <= prodi_next;
        pterm_reg     <= pterm_next;
        ihit_reg      <= ihit_next;
        phit_reg      <= phit_next;
        dmag_reg      <= dmag_next;
        neg_reg       <= neg_next;
        fac_reg       <= fac_next;
        per_reg       <= per_next;
        tprod_reg     <= tprod_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        res_drive_reg <= res_drive_next;
        res_ih_reg    <= res_ih_next;
        res_ph_reg    <= res_ph_next;
        m_drive_reg   <= m_drive_next;
        m_ih_reg      <= m_ih_next;
        m_ph_reg      <= m_ph_next;
    end

    // integral never leaves its clamp range
    a_integ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (integ_reg <= ILIM_HI) && (integ_reg >= ILIM_LO))
        else $error("integral outside clamp range");

    // a disabled word clears the whole regulator state
    a_disable_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !s_enable) |=> (integ_reg == '0) && (prev_reg == '0) && (cur_reg == '0))
        else $error("disable did not clear state");

    // divider remainder stays below the period
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TDIV) |-> (rem_reg < per_reg))
        else $error("divider remainder not below period");

    // interpolated step never exceeds the full difference
    a_quo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TFIN) |-> (quo_reg <= dmag_reg))
        else $error("interpolation step beyond difference");

endmodule

`default_nettype wire
